>>> rtl/wsd_pkg.sv
// shared types and constants of the window standard deviation and rms block
package wsd_pkg;

  // fixed widths of the request and result fields
  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned OUT_W    = 24;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_SQ_OLD,
    OP_SUB,
    OP_ADD,
    OP_MUL_A_LOAD,
    OP_MUL_B_LOAD,
    OP_MUL_STEP,
    OP_SQRT_S_LOAD,
    OP_SQRT_R_LOAD,
    OP_SQRT_STEP,
    OP_DIV,
    OP_PUBLISH
  } op_e;

  // command from controller to datapath
  typedef struct packed {
    op_e op;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic full;
    logic mul_done;
    logic iter_done;
    logic out_free;
  } status_t;

endpackage

>>> rtl/wsd_in_if.sv
// request channel carrying one distance sample
interface wsd_in_if;
  logic                         valid;
  logic                         ready;
  logic [wsd_pkg::SAMPLE_W-1:0] distance_sample;

  modport source (output valid, output distance_sample, input ready);
  modport sink (input valid, input distance_sample, output ready);
endinterface

>>> rtl/wsd_out_if.sv
// result channel carrying window flag, standard deviation and rms
interface wsd_out_if;
  logic                      valid;
  logic                      ready;
  logic                      window_full;
  logic [wsd_pkg::OUT_W-1:0] std_deviation;
  logic [wsd_pkg::OUT_W-1:0] rms_value;

  modport source (output valid, output window_full, output std_deviation,
                  output rms_value, input ready);
  modport sink (input valid, input window_full, input std_deviation,
                input rms_value, output ready);
endinterface

>>> rtl/wsd_ctrl.sv
// controller state machine sequencing the window statistics datapath
module wsd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  wsd_pkg::status_t status_i,
  output wsd_pkg::cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ_OLD,
    S_SUB,
    S_ADD,
    S_START,
    S_MUL_A,
    S_MUL_B,
    S_SQRT_S,
    S_DIV_S,
    S_SQRT_R,
    S_DIV_R,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  assign req_ready_o = (state_q == S_IDLE);

  // next state and command decode
  always_comb begin
    state_d    = state_q;
    cmd_o.op   = wsd_pkg::OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.op = wsd_pkg::OP_CAPTURE;
          state_d  = S_SQ_OLD;
        end
      end
      S_SQ_OLD: begin
        cmd_o.op = wsd_pkg::OP_SQ_OLD;
        state_d  = S_SUB;
      end
      S_SUB: begin
        cmd_o.op = wsd_pkg::OP_SUB;
        state_d  = S_ADD;
      end
      S_ADD: begin
        cmd_o.op = wsd_pkg::OP_ADD;
        state_d  = S_START;
      end
      S_START: begin
        if (status_i.full) begin
          cmd_o.op = wsd_pkg::OP_MUL_A_LOAD;
          state_d  = S_MUL_A;
        end else begin
          state_d = S_DONE;
        end
      end
      S_MUL_A: begin
        if (status_i.mul_done) begin
          cmd_o.op = wsd_pkg::OP_MUL_B_LOAD;
          state_d  = S_MUL_B;
        end else begin
          cmd_o.op = wsd_pkg::OP_MUL_STEP;
        end
      end
      S_MUL_B: begin
        if (status_i.mul_done) begin
          cmd_o.op = wsd_pkg::OP_SQRT_S_LOAD;
          state_d  = S_SQRT_S;
        end else begin
          cmd_o.op = wsd_pkg::OP_MUL_STEP;
        end
      end
      S_SQRT_S: begin
        if (status_i.iter_done) begin
          cmd_o.op = wsd_pkg::OP_DIV;
          state_d  = S_DIV_S;
        end else begin
          cmd_o.op = wsd_pkg::OP_SQRT_STEP;
        end
      end
      S_DIV_S: begin
        cmd_o.op = wsd_pkg::OP_SQRT_R_LOAD;
        state_d  = S_SQRT_R;
      end
      S_SQRT_R: begin
        if (status_i.iter_done) begin
          cmd_o.op = wsd_pkg::OP_DIV;
          state_d  = S_DIV_R;
        end else begin
          cmd_o.op = wsd_pkg::OP_SQRT_STEP;
        end
      end
      S_DIV_R: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.op = wsd_pkg::OP_PUBLISH;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/wsd_dp.sv
// datapath: sample ring, running sums, shift-add multiplier, root and divider
module wsd_dp #(
  parameter int WINDOW      = 100,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  wsd_pkg::cmd_t                cmd_i,
  input  logic [wsd_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                         res_ready_i,
  output wsd_pkg::status_t             status_o,
  output logic                         res_valid_o,
  output logic                         window_full_o,
  output logic [wsd_pkg::OUT_W-1:0]    std_deviation_o,
  output logic [wsd_pkg::OUT_W-1:0]    rms_value_o
);

  localparam int CW       = $clog2(WINDOW + 1);
  localparam int PW       = $clog2(WINDOW);
  localparam int SB       = SAMPLE_BITS;
  localparam int SUM_W    = SB + CW;
  localparam int SQ_W     = 2 * SB + CW;
  localparam int NUM_W    = SQ_W + CW;
  localparam int ROOT_W   = (NUM_W + 1) / 2;
  localparam int SQ_IN_W  = 2 * ROOT_W;
  localparam int REM_W    = ROOT_W + 2;
  localparam int IW       = $clog2(ROOT_W + 1);
  localparam int OW       = wsd_pkg::OUT_W;

  // reciprocal of the window length, exact floor division for any root
  localparam int RS    = ROOT_W + PW;
  localparam int RCP_W = ROOT_W + 2;
  localparam int QP_W  = ROOT_W + RCP_W;
  localparam logic [RS:0] RCP_FULL =
    ({1'b1, {RS{1'b0}}} + (RS + 1)'(WINDOW - 1)) / (RS + 1)'(WINDOW);
  localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_FULL);

  // sample ring
  logic [SB-1:0] ring_mem [WINDOW];
  logic [SB-1:0] rd_q;

  // control state
  logic [PW-1:0]    pos_q, pos_d;
  logic [CW-1:0]    fill_q, fill_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [SQ_W-1:0]  sumsq_q, sumsq_d;
  logic [IW-1:0]    iter_q, iter_d;
  logic             out_valid_q, out_valid_d;

  // payload registers
  logic [SB-1:0]      samp_q, samp_d;
  logic [2*SB-1:0]    sq_q, sq_d;
  logic [NUM_W-1:0]   mcand_q, mcand_d;
  logic [SUM_W-1:0]   mplier_q, mplier_d;
  logic [NUM_W-1:0]   prod_q, prod_d;
  logic [NUM_W-1:0]   a_q, a_d;
  logic [SQ_IN_W-1:0] sqrt_v_q, sqrt_v_d;
  logic [REM_W-1:0]   sqrt_rem_q, sqrt_rem_d;
  logic [ROOT_W-1:0]  sqrt_root_q, sqrt_root_d;
  logic [ROOT_W-1:0]  div_q, div_d;
  logic [ROOT_W-1:0]  std_q, std_d;
  logic               full_out_q, full_out_d;
  logic [OW-1:0]      std_out_q, std_out_d;
  logic [OW-1:0]      rms_out_q, rms_out_d;

  // step helpers
  logic            full;
  logic [SB-1:0]   sq_a;
  logic [2*SB-1:0] sq_prod;
  logic [REM_W-1:0] sqrt_rem_sh, sqrt_trial;
  logic            sqrt_ge;
  logic [QP_W-1:0] quot_prod;

  assign full = (fill_q == CW'(WINDOW));

  // one squarer shared by the old and the new sample
  assign sq_a    = (cmd_i.op == wsd_pkg::OP_SQ_OLD) ? rd_q : samp_q;
  assign sq_prod = sq_a * sq_a;

  // one root bit per step
  assign sqrt_rem_sh = {sqrt_rem_q[ROOT_W-1:0], sqrt_v_q[SQ_IN_W-1 -: 2]};
  assign sqrt_trial  = {sqrt_root_q, 2'b01};
  assign sqrt_ge     = (sqrt_rem_sh >= sqrt_trial);

  // root divided by the window length through its reciprocal
  assign quot_prod = QP_W'(sqrt_root_q) * QP_W'(RCP);

  assign status_o.full      = full;
  assign status_o.mul_done  = (mplier_q == '0);
  assign status_o.iter_done = (iter_q == IW'(ROOT_W));
  assign status_o.out_free  = !out_valid_q || res_ready_i;

  assign res_valid_o     = out_valid_q;
  assign window_full_o   = full_out_q;
  assign std_deviation_o = std_out_q;
  assign rms_value_o     = rms_out_q;

  // next-value decode per command
  always_comb begin
    pos_d       = pos_q;
    fill_d      = fill_q;
    sum_d       = sum_q;
    sumsq_d     = sumsq_q;
    iter_d      = iter_q;
    out_valid_d = out_valid_q;
    samp_d      = samp_q;
    sq_d        = sq_q;
    mcand_d     = mcand_q;
    mplier_d    = mplier_q;
    prod_d      = prod_q;
    a_d         = a_q;
    sqrt_v_d    = sqrt_v_q;
    sqrt_rem_d  = sqrt_rem_q;
    sqrt_root_d = sqrt_root_q;
    div_d       = div_q;
    std_d       = std_q;
    full_out_d  = full_out_q;
    std_out_d   = std_out_q;
    rms_out_d   = rms_out_q;

    if (out_valid_q && res_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (cmd_i.op)
      wsd_pkg::OP_CAPTURE: begin
        samp_d = SB'(sample_i);
      end
      wsd_pkg::OP_SQ_OLD: begin
        sq_d = sq_prod;
      end
      wsd_pkg::OP_SUB: begin
        // oldest sample leaves the sums once the window is full
        if (full) begin
          sum_d   = sum_q - SUM_W'(rd_q);
          sumsq_d = sumsq_q - SQ_W'(sq_q);
        end else begin
          fill_d = fill_q + 1'b1;
        end
        sq_d = sq_prod;
      end
      wsd_pkg::OP_ADD: begin
        sum_d   = sum_q + SUM_W'(samp_q);
        sumsq_d = sumsq_q + SQ_W'(sq_q);
        pos_d   = (pos_q == PW'(WINDOW - 1)) ? '0 : pos_q + 1'b1;
      end
      wsd_pkg::OP_MUL_A_LOAD: begin
        mcand_d  = NUM_W'(sumsq_q);
        mplier_d = SUM_W'(WINDOW);
        prod_d   = '0;
      end
      wsd_pkg::OP_MUL_B_LOAD: begin
        a_d      = prod_q;
        mcand_d  = NUM_W'(sum_q);
        mplier_d = sum_q;
        prod_d   = '0;
      end
      wsd_pkg::OP_MUL_STEP: begin
        if (mplier_q[0]) begin
          prod_d = prod_q + mcand_q;
        end
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
      end
      wsd_pkg::OP_SQRT_S_LOAD: begin
        // variance numerator, never negative
        sqrt_v_d    = SQ_IN_W'(a_q - prod_q);
        sqrt_rem_d  = '0;
        sqrt_root_d = '0;
        iter_d      = '0;
      end
      wsd_pkg::OP_SQRT_R_LOAD: begin
        std_d       = div_q;
        sqrt_v_d    = SQ_IN_W'(a_q);
        sqrt_rem_d  = '0;
        sqrt_root_d = '0;
        iter_d      = '0;
      end
      wsd_pkg::OP_SQRT_STEP: begin
        sqrt_v_d = sqrt_v_q << 2;
        if (sqrt_ge) begin
          sqrt_rem_d  = sqrt_rem_sh - sqrt_trial;
          sqrt_root_d = {sqrt_root_q[ROOT_W-2:0], 1'b1};
        end else begin
          sqrt_rem_d  = sqrt_rem_sh;
          sqrt_root_d = {sqrt_root_q[ROOT_W-2:0], 1'b0};
        end
        iter_d = iter_q + 1'b1;
      end
      wsd_pkg::OP_DIV: begin
        div_d = ROOT_W'(quot_prod[QP_W-1:RS]);
      end
      wsd_pkg::OP_PUBLISH: begin
        out_valid_d = 1'b1;
        full_out_d  = full;
        std_out_d   = full ? OW'(std_q) : '0;
        rms_out_d   = full ? OW'(div_q) : '0;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      sumsq_q     <= '0;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      fill_q      <= fill_d;
      sum_q       <= sum_d;
      sumsq_q     <= sumsq_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    samp_q      <= samp_d;
    sq_q        <= sq_d;
    mcand_q     <= mcand_d;
    mplier_q    <= mplier_d;
    prod_q      <= prod_d;
    a_q         <= a_d;
    sqrt_v_q    <= sqrt_v_d;
    sqrt_rem_q  <= sqrt_rem_d;
    sqrt_root_q <= sqrt_root_d;
    div_q       <= div_d;
    std_q       <= std_d;
    full_out_q  <= full_out_d;
    std_out_q   <= std_out_d;
    rms_out_q   <= rms_out_d;
  end

  // ring write and registered read at the current slot
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == wsd_pkg::OP_ADD) begin
      ring_mem[pos_q] <= samp_q;
    end
    rd_q <= ring_mem[pos_q];
  end

endmodule

>>> rtl/window_std_dev_and_rms.sv
// top level of the sliding window standard deviation and rms block
//
// usage: one distance sample in millimetres enters per request on req_i
// (valid/ready); exactly one result leaves per request on res_o, in order.
// The block keeps the last WINDOW samples and their running sum and sum of
// squares. Until WINDOW samples have been seen, window_full is 0 and both
// statistics are 0. Afterwards std_deviation = floor(sqrt(var)) and
// rms_value = floor(sqrt(mean square)), both floored, in millimetres.
// One request is worked on at a time. With the window still filling, the
// sample is captured and added to the sums before the result is published;
// with a full window the shift-add multiplier (one step per bit of WINDOW
// and then of the running sum) and two bit-serial root passes, each followed
// by a reciprocal division by WINDOW, come first. A new request is taken
// the cycle after the previous result enters the output register.
// The output register holds a result until res_o.ready; while it is full
// the next result waits in the controller. Reset clears the sums, the fill
// count and the ring pointer; ring contents are not cleared.
module window_std_dev_and_rms #(
  parameter int WINDOW      = 100,
  parameter int SAMPLE_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  wsd_in_if.sink      req_i,
  wsd_out_if.source   res_o
);

  wsd_pkg::cmd_t    cmd;
  wsd_pkg::status_t status;

  // sequencer
  wsd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // arithmetic and storage
  wsd_dp #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sample_i        (req_i.distance_sample),
    .res_ready_i     (res_o.ready),
    .status_o        (status),
    .res_valid_o     (res_o.valid),
    .window_full_o   (res_o.window_full),
    .std_deviation_o (res_o.std_deviation),
    .rms_value_o     (res_o.rms_value)
  );

`ifndef ASSERT_OFF
  // only one request in flight
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request accepted while previous one in flight");

  // statistics are zero until the window is full
  a_zero_when_filling: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.window_full) |->
      (res_o.std_deviation == '0 && res_o.rms_value == '0))
    else $error("nonzero statistics before window full");

  // standard deviation never exceeds rms
  a_std_below_rms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.std_deviation <= res_o.rms_value))
    else $error("standard deviation above rms");
`endif

endmodule

>>> tb/window_stats_checker.sv
// checker that predicts and compares window standard deviation and rms results
module window_stats_checker #(
  parameter int WINDOW = 100
) (
  input  logic clk_i,
  input  logic rst_ni,
  wsd_in_if    req_mon,
  wsd_out_if   res_mon,
  output int   mismatches_o,
  output int   outstanding_o,
  output int   results_o,
  output int   full_results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W = wsd_pkg::SAMPLE_W;
  localparam int OUT_W    = wsd_pkg::OUT_W;

  typedef struct packed {
    logic              window_full;
    logic [OUT_W-1:0]  std_deviation;
    logic [OUT_W-1:0]  rms_value;
  } window_stats_t;

  // predicted window contents and running sums
  logic [SAMPLE_W-1:0] held_samples [WINDOW];
  int unsigned         next_slot;
  int unsigned         held_count;
  logic [63:0]         window_sum;
  logic [63:0]         window_sum_sq;

  window_stats_t       expected_stats [$];
  int                  mismatch_count;
  int                  outstanding;
  int                  results_checked;
  int                  full_results;

  assign mismatches_o   = mismatch_count;
  assign outstanding_o  = outstanding;
  assign results_o      = results_checked;
  assign full_results_o = full_results;

  // floor of the square root, settling one root bit at a time from the top
  function automatic logic [31:0] floor_root(input logic [63:0] radicand);
    logic [31:0] root;
    logic [31:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if ({32'd0, trial} * {32'd0, trial} <= radicand) root = trial;
    end
    return root;
  endfunction

  task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH %0t result %0d: %s got %0h wanted %0h",
             $time, results_checked, what, got, want);
    mismatch_count++;
  endtask

  // slide the window by one request and queue the statistics it should give
  task advance_window(input logic [SAMPLE_W-1:0] sample);
    logic [63:0]   fresh;
    logic [63:0]   oldest;
    logic [63:0]   scaled_sq;
    logic [63:0]   sum_squared;
    logic [63:0]   variance;
    window_stats_t want;
    fresh = 64'(sample);
    // oldest sample leaves before the new one enters
    if (held_count == WINDOW) begin
      oldest        = 64'(held_samples[next_slot]);
      window_sum    = window_sum - oldest;
      window_sum_sq = window_sum_sq - oldest * oldest;
    end else begin
      held_count++;
    end
    held_samples[next_slot] = sample;
    window_sum    = window_sum + fresh;
    window_sum_sq = window_sum_sq + fresh * fresh;
    next_slot     = (next_slot == WINDOW - 1) ? 0 : next_slot + 1;

    want = '0;
    if (held_count == WINDOW) begin
      scaled_sq   = 64'(WINDOW) * window_sum_sq;
      sum_squared = window_sum * window_sum;
      // guard against a negative numerator, which the exact sums never give
      variance    = (scaled_sq > sum_squared) ?
                    (scaled_sq - sum_squared) / (64'(WINDOW) * 64'(WINDOW)) : 64'd0;
      want.window_full   = 1'b1;
      want.std_deviation = OUT_W'(floor_root(variance));
      want.rms_value     = OUT_W'(floor_root(window_sum_sq / 64'(WINDOW)));
    end
    expected_stats.push_back(want);
    outstanding++;
  endtask

  // compare one accepted result with the oldest prediction
  task check_result();
    window_stats_t want;
    if (expected_stats.size() == 0) begin
      report_mismatch("result with no request outstanding", '0, '0);
    end else begin
      want = expected_stats.pop_front();
      outstanding--;
      if (res_mon.window_full !== want.window_full)
        report_mismatch("window_full", 32'(res_mon.window_full), 32'(want.window_full));
      if (res_mon.std_deviation !== want.std_deviation)
        report_mismatch("std_deviation", 32'(res_mon.std_deviation), 32'(want.std_deviation));
      if (res_mon.rms_value !== want.rms_value)
        report_mismatch("rms_value", 32'(res_mon.rms_value), 32'(want.rms_value));
    end
    if (res_mon.window_full === 1'b1) full_results++;
    results_checked++;
  endtask

  // watch both channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_slot     = 0;
      held_count    = 0;
      window_sum    = '0;
      window_sum_sq = '0;
      outstanding   = 0;
      expected_stats.delete();
    end else begin
      if (res_mon.valid === 1'b1 && res_mon.ready === 1'b1) check_result();
      if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1)
        advance_window(req_mon.distance_sample);
    end
  end

  initial begin
    mismatch_count  = 0;
    results_checked = 0;
    full_results    = 0;
  end

endmodule

>>> tb/window_std_dev_and_rms_test.sv
// top of the testbench: clock, reset, request stimulus, result stalls and verdict
module window_std_dev_and_rms_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          SAMPLE_W        = wsd_pkg::SAMPLE_W;
  localparam int          WINDOW          = 100;
  localparam int unsigned SAMPLE_MAX      = (1 << SAMPLE_W) - 1;
  localparam int          RESET_CYCLES    = 10;
  localparam int          RANDOM_SAMPLES  = 750;
  localparam int          DRAIN_CYCLES    = 400;
  localparam int          CYCLE_LIMIT     = 1_000_000;

  // shapes of the random sample segments
  typedef enum int {
    PAT_UNIFORM,
    PAT_ALL_MAX,
    PAT_ALL_ZERO,
    PAT_ALTERNATE,
    PAT_EXTREMES,
    PAT_SMALL,
    PAT_NEAR
  } sample_pattern_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  wsd_in_if  req_if ();
  wsd_out_if res_if ();

  int mismatches;
  int outstanding;
  int results_checked;
  int full_results;
  int samples_sent;
  int cycle_count;

  logic [SAMPLE_W-1:0] sample_plan [$];

  window_std_dev_and_rms #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_W)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  window_stats_checker #(
    .WINDOW (WINDOW)
  ) u_stats_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_mon        (req_if),
    .res_mon        (res_if),
    .mismatches_o   (mismatches),
    .outstanding_o  (outstanding),
    .results_o      (results_checked),
    .full_results_o (full_results)
  );

  always #5 clk_i = ~clk_i;

  // run limit
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still outstanding",
               cycle_count, outstanding);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [SAMPLE_W-1:0] pattern_sample(input sample_pattern_e pattern,
                                                         input int idx,
                                                         input logic [SAMPLE_W-1:0] base);
    case (pattern)
      PAT_ALL_MAX:   return SAMPLE_W'(SAMPLE_MAX);
      PAT_ALL_ZERO:  return '0;
      PAT_ALTERNATE: return idx[0] ? SAMPLE_W'(SAMPLE_MAX) : '0;
      PAT_EXTREMES:  return $urandom_range(0, 1) ? SAMPLE_W'(SAMPLE_MAX) : '0;
      PAT_SMALL:     return SAMPLE_W'($urandom_range(0, 15));
      PAT_NEAR:      return base + SAMPLE_W'($urandom_range(0, 7));
      default:       return SAMPLE_W'($urandom);
    endcase
  endfunction

  // present one request from the falling edge until it is accepted
  task automatic send_sample(input logic [SAMPLE_W-1:0] value);
    req_if.valid           <= 1'b1;
    req_if.distance_sample <= value;
    @(posedge clk_i);
    while (req_if.ready !== 1'b1) @(posedge clk_i);
    @(negedge clk_i);
    samples_sent++;
  endtask

  // result side stalls: random stall and run lengths, some stretches always ready
  initial begin
    int stall_len;
    int run_len;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      run_len   = (stall_len == 0) ? $urandom_range(100, 600) : $urandom_range(1, 60);
      repeat (stall_len) begin
        @(negedge clk_i);
        res_if.ready <= 1'b0;
      end
      repeat (run_len) begin
        @(negedge clk_i);
        res_if.ready <= 1'b1;
      end
    end
  end

  // request stimulus and verdict
  initial begin
    int                  burst_left;
    int                  seg_len;
    int                  planned;
    int                  pick;
    sample_pattern_e     pattern;
    logic [SAMPLE_W-1:0] base;

    req_if.valid           = 1'b0;
    req_if.distance_sample = '0;
    samples_sent           = 0;

    // directed: field extremes, single bit and mixed bit patterns while the window fills
    sample_plan = '{24'h000000, 24'hFFFFFF, 24'h000001, 24'hFFFFFE, 24'h800000,
                    24'h7FFFFF, 24'h555555, 24'hAAAAAA, 24'h000100, 24'h010000,
                    24'h123456, 24'hFEDCBA, 24'h000000, 24'hFFFFFF};

    // random: a full window of the maximum, then alternating extremes,
    // then segments of mixed shapes
    planned = 0;
    while (planned < RANDOM_SAMPLES) begin
      if (planned == 0) begin
        pattern = PAT_ALL_MAX;
        seg_len = WINDOW + 20;
      end else if (planned == WINDOW + 20) begin
        pattern = PAT_ALTERNATE;
        seg_len = WINDOW + 20;
      end else begin
        pick    = $urandom_range(0, 9);
        pattern = (pick > 6) ? PAT_UNIFORM : sample_pattern_e'(pick);
        seg_len = $urandom_range(20, 150);
      end
      base = SAMPLE_W'($urandom_range(0, SAMPLE_MAX - 7));
      for (int i = 0; i < seg_len && planned < RANDOM_SAMPLES; i++) begin
        sample_plan.push_back(pattern_sample(pattern, i, base));
        planned++;
      end
    end

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // bursts of requests with random gaps, now and then a long burst
    while (sample_plan.size() != 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      while (burst_left != 0 && sample_plan.size() != 0) begin
        send_sample(sample_plan.pop_front());
        burst_left--;
      end
      req_if.valid           <= 1'b0;
      req_if.distance_sample <= SAMPLE_W'($urandom);
      repeat ($urandom_range(1, 20)) @(negedge clk_i);
    end

    // drain, then allow for any stray result
    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run: %0d distance samples sent, %0d results checked", samples_sent,
             results_checked);
    $display("Run: %0d results over a full window, %0d cycles", full_results, cycle_count);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/wsd_pkg.sv
rtl/wsd_in_if.sv
rtl/wsd_out_if.sv
rtl/wsd_ctrl.sv
rtl/wsd_dp.sv
rtl/window_std_dev_and_rms.sv
tb/window_stats_checker.sv
tb/window_std_dev_and_rms_test.sv
